// File: rtl/fcpp_pkg.sv
// Shared types, constants and register indexes for the four-channel peak position block.
package fcpp_pkg;

  localparam int NUM_CHANNELS      = 4;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 15;
  localparam int FIELD_BITS        = 16;
  localparam int BOUND_BITS        = 18;
  localparam int POS_BITS          = 16;

  localparam logic [POS_BITS-1:0]   POS_MAX     = 16'd32767;
  localparam logic [BOUND_BITS-1:0] LOWER_RESET = 18'd220;
  localparam logic [BOUND_BITS-1:0] UPPER_RESET = 18'd40000;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SUM_LOWER = 1'b0,
    CFG_SUM_UPPER = 1'b1
  } cfg_idx_t;

  // One sample step of an event
  typedef struct packed {
    logic [FIELD_BITS-1:0] sample_a;
    logic [FIELD_BITS-1:0] sample_b;
    logic [FIELD_BITS-1:0] sample_c;
    logic [FIELD_BITS-1:0] sample_d;
    logic                  end_of_event;
  } in_req_t;

  // One position result per event
  typedef struct packed {
    logic [BOUND_BITS-1:0]      peak_sum;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic                       x_valid;
    logic                       y_valid;
    logic                       in_window;
  } out_res_t;

  // Status of one ratio unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/four_channel_peak_position.sv
// Top level: four peak lanes, two ratio units and the merging result stage.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------
//  in_      | in        | in_valid / in_stall   | in_req  (in_req_t)
//  out_     | out       | out_valid / out_stall | out_res (out_res_t)
//  cfg_     | in        | cfg_wr_en             | cfg_index, cfg_wdata
//
// One sample step is taken each cycle unless an end-of-event step is stalled; the lanes update
// their peaks in that cycle. An end-of-event request starts both ratio units (one quotient bit a
// cycle); the finished ratios are held until the output register frees and then move into it.
// An end-of-event request is stalled while the previous event is still in the ratio
// units or waiting for the output register; other requests are never stalled.
// Reset clears the peaks and loads the bounds with 220 and 40000.
module four_channel_peak_position #(
  parameter int SAMPLE_BITS   = fcpp_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = fcpp_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fcpp_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fcpp_pkg::out_res_t                out_res,
  input  logic                              cfg_wr_en,
  input  logic [0:0]                        cfg_index,
  input  logic [fcpp_pkg::BOUND_BITS-1:0]   cfg_wdata
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int BW    = fcpp_pkg::BOUND_BITS;
  localparam int NCH   = fcpp_pkg::NUM_CHANNELS;

  logic [SAMPLE_BITS-1:0] samples [NCH];
  logic [SAMPLE_BITS-1:0] finals  [NCH];
  logic                   in_acc;
  logic                   ev_start;
  logic                   occupied;
  logic                   xfer;

  logic [BW-1:0]    lower_r, lower_nxt;
  logic [BW-1:0]    upper_r, upper_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  fcpp_pkg::out_res_t out_res_r, out_res_nxt;

  fcpp_pkg::div_stat_t        x_stat, y_stat;
  logic signed [fcpp_pkg::POS_BITS-1:0] x_pos, y_pos;
  logic                       x_ok, y_ok;
  logic [BW-1:0]              sum_ext;

  // Hand the channel samples to the lanes
  assign samples[0] = in_req.sample_a[SAMPLE_BITS-1:0];
  assign samples[1] = in_req.sample_b[SAMPLE_BITS-1:0];
  assign samples[2] = in_req.sample_c[SAMPLE_BITS-1:0];
  assign samples[3] = in_req.sample_d[SAMPLE_BITS-1:0];

  // Stall only an end-of-event request that finds the ratio units in use
  assign occupied = x_stat.busy || y_stat.busy || hold_r;
  assign in_stall = occupied && in_req.end_of_event;
  assign in_acc   = in_valid && !in_stall;
  assign ev_start = in_acc && in_req.end_of_event;

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    fcpp_peak_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (in_acc),
      .last      (in_req.end_of_event),
      .sample    (samples[g]),
      .peak_final(finals[g])
    );
  end

  fcpp_ratio_div #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ev_start),
    .num_pos  (finals[0]),
    .num_neg  (finals[1]),
    .stat     (x_stat),
    .pos      (x_pos),
    .pos_valid(x_ok)
  );

  fcpp_ratio_div #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ev_start),
    .num_pos  (finals[3]),
    .num_neg  (finals[2]),
    .stat     (y_stat),
    .pos      (y_pos),
    .pos_valid(y_ok)
  );

  // Write the window bounds
  always_comb begin
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    if (cfg_wr_en) begin
      unique case (fcpp_pkg::cfg_idx_t'(cfg_index))
        fcpp_pkg::CFG_SUM_LOWER: lower_nxt = cfg_wdata;
        fcpp_pkg::CFG_SUM_UPPER: upper_nxt = cfg_wdata;
        default:                 lower_nxt = lower_r;
      endcase
    end
  end

  // Capture the peak sum at the end of the event
  assign sum_nxt = ev_start ? (SUM_W'(finals[0]) + SUM_W'(finals[1]) +
                               SUM_W'(finals[2]) + SUM_W'(finals[3])) : sum_r;
  assign sum_ext = BW'(sum_r);

  // Hold finished ratios until the output register frees
  assign xfer = hold_r && (!out_valid_r || !out_stall);

  always_comb begin
    hold_nxt = hold_r;
    if (x_stat.done && y_stat.done) begin
      hold_nxt = 1'b1;
    end else if (xfer) begin
      hold_nxt = 1'b0;
    end
  end

  // Merge lane and ratio results into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (xfer) begin
      out_valid_nxt         = 1'b1;
      out_res_nxt.peak_sum  = sum_ext;
      out_res_nxt.pos_x     = x_pos;
      out_res_nxt.pos_y     = y_pos;
      out_res_nxt.x_valid   = x_ok;
      out_res_nxt.y_valid   = y_ok;
      out_res_nxt.in_window = (sum_ext > lower_r) && (sum_ext < upper_r);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r     <= fcpp_pkg::LOWER_RESET;
      upper_r     <= fcpp_pkg::UPPER_RESET;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sum_r     <= sum_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/fcpp_peak_lane.sv
// One channel lane: running peak of the samples within an event.
module fcpp_peak_lane #(
  parameter int SAMPLE_BITS = fcpp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   last,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] peak_final
);

  logic [SAMPLE_BITS-1:0] peak_r;
  logic [SAMPLE_BITS-1:0] peak_nxt;

  // Fold the current sample into the peak
  assign peak_final = (sample > peak_r) ? sample : peak_r;

  // Advance on each request, drop back to zero after the last one
  always_comb begin
    peak_nxt = peak_r;
    if (accept) begin
      peak_nxt = last ? '0 : peak_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

endmodule

// File: rtl/fcpp_ratio_div.sv
// Iterative ratio unit: (pos-neg)/(pos+neg) in signed fixed point, one quotient bit a cycle.
module fcpp_ratio_div #(
  parameter int SAMPLE_BITS   = fcpp_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = fcpp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [SAMPLE_BITS-1:0]               num_pos,
  input  logic [SAMPLE_BITS-1:0]               num_neg,
  output fcpp_pkg::div_stat_t                  stat,
  output logic signed [fcpp_pkg::POS_BITS-1:0] pos,
  output logic                                 pos_valid
);

  localparam int DEN_W = SAMPLE_BITS + 1;
  localparam int REM_W = SAMPLE_BITS + 2;
  localparam int Q_W   = FRACTION_BITS + 1;
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam int PW    = fcpp_pkg::POS_BITS;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic             neg_r, neg_nxt;
  logic             last_step;
  logic [DEN_W-1:0] den_in;
  logic [REM_W-1:0] trial;
  logic             fits;
  logic [PW-1:0]    q_ext;
  logic [PW-1:0]    mag_sat;

  assign den_in    = DEN_W'(num_pos) + DEN_W'(num_neg);
  assign last_step = busy_r && (cnt_r == CNT_W'(FRACTION_BITS));

  // Restoring step: compare, subtract, shift
  assign fits  = rem_r >= REM_W'(den_r);
  assign trial = fits ? (rem_r - REM_W'(den_r)) : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den_in;
      q_nxt    = '0;
      neg_nxt  = num_neg > num_pos;
      rem_nxt  = (num_neg > num_pos) ? REM_W'(num_neg - num_pos)
                                     : REM_W'(num_pos - num_neg);
    end else if (busy_r) begin
      q_nxt   = {q_r[Q_W-2:0], fits};
      rem_nxt = {trial[REM_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = last_step;

  // Saturate just below +1, apply sign, force zero on an empty denominator
  assign q_ext     = PW'(q_r);
  assign mag_sat   = (!neg_r && (q_ext > fcpp_pkg::POS_MAX)) ? fcpp_pkg::POS_MAX : q_ext;
  assign pos_valid = den_r != '0;

  always_comb begin
    if (!pos_valid) begin
      pos = '0;
    end else if (neg_r) begin
      pos = $signed(~q_ext + PW'(1));
    end else begin
      pos = $signed(mag_sat);
    end
  end

endmodule

// File: bench/peak_position_checker.sv
// Checker for the four-channel peak position block: watches the channels, predicts and compares.
module peak_position_checker
  import fcpp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_req_t               in_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_res_t              out_res,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [BOUND_BITS-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    results_owed
);

  localparam logic [FIELD_BITS-1:0] SAMPLE_MASK =
    FIELD_BITS'((32'd1 << SAMPLE_BITS_DEF) - 1);

  logic [FIELD_BITS-1:0] running_peak [NUM_CHANNELS];
  logic [BOUND_BITS-1:0] lower_bound;
  logic [BOUND_BITS-1:0] upper_bound;
  out_res_t              positions_due [$];

  // Normalised difference (plus - minus) / (plus + minus) in signed Q1.15
  function automatic void q15_ratio(input  logic [FIELD_BITS-1:0]    plus,
                                    input  logic [FIELD_BITS-1:0]    minus,
                                    output logic signed [POS_BITS-1:0] q,
                                    output logic                     ok);
    logic [FIELD_BITS:0]   den;
    logic [FIELD_BITS-1:0] mag;
    logic [31:0]           quot;
    logic                  neg;
    den = {1'b0, plus} + {1'b0, minus};
    neg = minus > plus;
    mag = neg ? minus - plus : plus - minus;
    if (den == '0) begin
      q  = '0;
      ok = 1'b0;
    end else begin
      quot = ({16'b0, mag} << FRACTION_BITS_DEF) / {15'b0, den};
      // exactly +1 does not fit, clip it; -1 does
      if (!neg && quot > 32'(POS_MAX)) quot = 32'(POS_MAX);
      q  = neg ? POS_BITS'(32'd0 - quot) : POS_BITS'(quot);
      ok = 1'b1;
    end
  endfunction

  // Position result for the peaks held so far
  function automatic out_res_t predict_position();
    out_res_t                   r;
    logic [BOUND_BITS-1:0]      sum;
    logic signed [POS_BITS-1:0] qx;
    logic signed [POS_BITS-1:0] qy;
    logic                       okx;
    logic                       oky;
    sum = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) sum += BOUND_BITS'(running_peak[ch]);
    q15_ratio(running_peak[0], running_peak[1], qx, okx);
    q15_ratio(running_peak[3], running_peak[2], qy, oky);
    r.peak_sum  = sum;
    r.pos_x     = qx;
    r.pos_y     = qy;
    r.x_valid   = okx;
    r.y_valid   = oky;
    r.in_window = (sum > lower_bound) && (sum < upper_bound);
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_res_t              want;
    logic [FIELD_BITS-1:0] step_sample [NUM_CHANNELS];
    if (!rst_n) begin
      // Hold the reset state
      for (int ch = 0; ch < NUM_CHANNELS; ch++) running_peak[ch] = '0;
      lower_bound = LOWER_RESET;
      upper_bound = UPPER_RESET;
      positions_due.delete();
      mismatch_count = 0;
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SUM_LOWER: lower_bound = cfg_wdata;
          CFG_SUM_UPPER: upper_bound = cfg_wdata;
        endcase
      end

      // Compare each delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (positions_due.size() == 0) begin
          $error("result with none due: peak_sum %0d", out_res.peak_sum);
          mismatch_count++;
        end else begin
          want = positions_due.pop_front();
          check_field("peak_sum", {14'b0, want.peak_sum}, {14'b0, out_res.peak_sum});
          check_field("pos_x", $signed(want.pos_x), $signed(out_res.pos_x));
          check_field("pos_y", $signed(want.pos_y), $signed(out_res.pos_y));
          check_field("x_valid", {31'b0, want.x_valid}, {31'b0, out_res.x_valid});
          check_field("y_valid", {31'b0, want.y_valid}, {31'b0, out_res.y_valid});
          check_field("in_window", {31'b0, want.in_window}, {31'b0, out_res.in_window});
        end
      end

      // Fold each accepted request into the peaks; close the event on its last step
      if (in_valid && !in_stall) begin
        step_sample[0] = in_req.sample_a & SAMPLE_MASK;
        step_sample[1] = in_req.sample_b & SAMPLE_MASK;
        step_sample[2] = in_req.sample_c & SAMPLE_MASK;
        step_sample[3] = in_req.sample_d & SAMPLE_MASK;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
          if (step_sample[ch] > running_peak[ch]) running_peak[ch] = step_sample[ch];
        if (in_req.end_of_event) begin
          positions_due.push_back(predict_position());
          for (int ch = 0; ch < NUM_CHANNELS; ch++) running_peak[ch] = '0;
        end
      end
    end
    results_owed = positions_due.size();
  end

endmodule

// File: bench/tb_top.sv
// Top of the four-channel peak position testbench: clock, reset, stimulus and verdict.
module tb_top;
  import fcpp_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_STEPS  = 215;
  localparam int NUM_PHASES   = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_req;
  logic                  out_valid;
  logic                  out_stall;
  out_res_t              out_res;
  logic                  cfg_wr_en;
  logic [0:0]            cfg_index;
  logic [BOUND_BITS-1:0] cfg_wdata;

  int mismatch_count;
  int results_owed;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  four_channel_peak_position dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  peak_position_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when asked for one
  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_req_t step_of(input logic [FIELD_BITS-1:0] a,
                                      input logic [FIELD_BITS-1:0] b,
                                      input logic [FIELD_BITS-1:0] c,
                                      input logic [FIELD_BITS-1:0] d,
                                      input logic                  last);
    in_req_t r;
    r.sample_a     = a;
    r.sample_b     = b;
    r.sample_c     = c;
    r.sample_d     = d;
    r.end_of_event = last;
    return r;
  endfunction

  // Mix of zeros, full scale, small pulses and anything
  function automatic logic [FIELD_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return FIELD_BITS'($urandom_range(0, 120));
      5:       return FIELD_BITS'($urandom_range(0, 12000));
      default: return FIELD_BITS'($urandom());
    endcase
  endfunction

  // Offer one request after a random gap and hold it until taken; returns at a falling edge
  task automatic send_step(input in_req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One event of random samples; sometimes a channel pair stays at zero
  task automatic send_event(input int n_steps);
    int      zero_mode;
    in_req_t r;
    zero_mode = $urandom_range(0, 7);
    for (int k = 0; k < n_steps; k++) begin
      r.sample_a = pick_sample();
      r.sample_b = pick_sample();
      r.sample_c = pick_sample();
      r.sample_d = pick_sample();
      if (zero_mode == 0) begin
        r.sample_a = '0;
        r.sample_b = '0;
      end else if (zero_mode == 1) begin
        r.sample_c = '0;
        r.sample_d = '0;
      end
      r.end_of_event = (k == n_steps - 1);
      send_step(r);
    end
  endtask

  // Drop valid, wait for every result, then let the ratio units run dry
  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_bounds(input logic [BOUND_BITS-1:0] lo,
                                input logic [BOUND_BITS-1:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SUM_LOWER;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_SUM_UPPER;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int steps_sent;
    int lo;
    int hi;
    int len;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of the samples and ratios, under the reset bounds
    send_step(step_of(16'd0, 16'd0, 16'd0, 16'd0, 1'b1));          // both denominators zero
    send_step(step_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_step(step_of(16'd1000, 16'd0, 16'd0, 16'd500, 1'b1));     // +1 on both, clipped
    send_step(step_of(16'd0, 16'd1000, 16'd700, 16'd0, 1'b1));     // -1 on both
    send_step(step_of(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0));
    send_step(step_of(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b1));
    // peaks carried over several steps, last step folded in too
    send_step(step_of(16'd100, 16'd200, 16'd300, 16'd400, 1'b0));
    send_step(step_of(16'd50, 16'd900, 16'd10, 16'd20, 1'b0));
    send_step(step_of(16'd7, 16'd7, 16'd7, 16'd7, 1'b1));
    // window edges: on the bounds is outside
    send_step(step_of(16'd220, 16'd0, 16'd0, 16'd0, 1'b1));
    send_step(step_of(16'd221, 16'd0, 16'd0, 16'd0, 1'b1));
    send_step(step_of(16'd20000, 16'd19999, 16'd0, 16'd0, 1'b1));
    send_step(step_of(16'd20000, 16'd20000, 16'd0, 16'd0, 1'b1));
    // truncation toward zero on both signs
    send_step(step_of(16'd3, 16'd1, 16'd2, 16'd5, 1'b1));
    send_step(step_of(16'd1, 16'd2, 16'd65535, 16'd1, 1'b1));
    settle();

    // Widest window
    program_bounds(18'd0, 18'h3FFFF);
    send_step(step_of(16'd1, 16'd0, 16'd0, 16'd0, 1'b1));
    send_step(step_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    settle();

    // Inverted window
    program_bounds(18'h3FFFF, 18'd0);
    send_step(step_of(16'd300, 16'd0, 16'd0, 16'd0, 1'b1));
    settle();

    // Empty window
    program_bounds(18'd100, 18'd101);
    send_step(step_of(16'd50, 16'd51, 16'd0, 16'd0, 1'b1));
    send_step(step_of(16'd50, 16'd50, 16'd0, 16'd0, 1'b1));
    settle();

    // Random events, one setting and one idling pattern per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 6) begin
        lo = 0;
        hi = 262143;
      end else begin
        lo = $urandom_range(0, 3000);
        hi = lo + $urandom_range(0, 150000);
        if (hi > 262143) hi = 262143;
      end
      program_bounds(BOUND_BITS'(lo), BOUND_BITS'(hi));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // hold the receiver off while the sender keeps pushing, so the block backs up
      if (ph == 4) hold_req = 1'b1;
      steps_sent = 0;
      while (steps_sent < PHASE_STEPS) begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        send_event(len);
        steps_sent += len;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: four_channel_peak_position.f
rtl/fcpp_pkg.sv
rtl/fcpp_peak_lane.sv
rtl/fcpp_ratio_div.sv
rtl/four_channel_peak_position.sv
bench/peak_position_checker.sv
bench/tb_top.sv
